// ----- rtl/core/bfds_pkg.sv -----
`timescale 1ns / 1ps
package bfds_pkg;
    localparam int MAX_DST_WIDTH = 256;
    localparam int MAX_SRC_SIZE  = 4096;
    localparam int SUM_W = 32;
    localparam int SCL_W = 13;
    localparam int AREA_W = 26;

    typedef enum logic [2:0] {
        CFG_SRC_W  = 3'd0,
        CFG_SRC_H  = 3'd1,
        CFG_DST_W  = 3'd2,
        CFG_DST_H  = 3'd3,
        CFG_ALPHA  = 3'd4
    } cfg_idx_t;

    // one pixel handed to the output divider
    typedef struct packed {
        logic [3:0][SUM_W-1:0] sums;
        logic                  alpha;
        logic                  last;
    } div_req_t;
endpackage

// ----- rtl/core/bfds_div.sv -----
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, four channels in parallel
module bfds_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  bfds_pkg::div_req_t          req,
    input  logic [bfds_pkg::AREA_W-1:0] divisor,
    output logic                        busy,
    output logic                        done,
    output logic [3:0][7:0]             quot,
    output logic                        last
);
    localparam int W = bfds_pkg::SUM_W;
    localparam int CW = $clog2(W + 1);

    logic [3:0][W-1:0] rem_reg;
    logic [3:0][W-1:0] q_reg;
    logic [W+bfds_pkg::AREA_W-1:0] dv_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, done_reg, alpha_reg, last_reg;
    logic [3:0][W-1:0] rem_next, q_next;

    // one shift-subtract step per channel
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            rem_next[c] = rem_reg[c];
            q_next[c] = {q_reg[c][W-2:0], 1'b0};
            if ({{bfds_pkg::AREA_W{1'b0}}, rem_reg[c]} >= dv_reg) begin
                rem_next[c] = rem_reg[c] - dv_reg[W-1:0];
                q_next[c][0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= CW'(W);
            rem_reg <= req.sums;
            q_reg <= '0;
            dv_reg <= {divisor, {(W-1){1'b0}}, 1'b0} >> 1;
            alpha_reg <= req.alpha;
            last_reg <= req.last;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            dv_reg <= dv_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign last = last_reg;
    always_comb begin
        for (int c = 0; c < 4; c++) quot[c] = q_reg[c][7:0];
        if (!alpha_reg) quot[3] = '0;
    end
endmodule

// ----- rtl/core/box_filter_image_downscaler.sv -----
`timescale 1ns / 1ps
// m_valid rises after the closing item of a block is accepted, once its sums pass the RMW state,
// the divider and the output register; an item that also opens an image first waits for scale division
// items are taken one at a time (sum read, then write back), an image's first after scale division;
// a closing item also waits until the divider and the output register are free
// reset: synchronous active low; counters clear, registers return to 1/1/1/1/alpha on,
// sum memory needs no clearing, each block writes its entries before reading
module box_filter_image_downscaler #(
    parameter int MAX_DST_WIDTH = bfds_pkg::MAX_DST_WIDTH,
    parameter int MAX_SRC_SIZE  = bfds_pkg::MAX_SRC_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [7:0]  s_alpha_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic [7:0]  m_alpha_out,
    output logic        m_last_pixel
);
    localparam int AW = $clog2(MAX_DST_WIDTH);
    localparam int PW = $clog2(MAX_SRC_SIZE + 1);
    localparam int SW = bfds_pkg::SUM_W;
    localparam int AR = bfds_pkg::AREA_W;
    localparam int CNT_W = $clog2(PW + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_LATCH, ST_RMW, ST_WAIT} state_t;

    // configuration registers
    logic [12:0] src_w_reg, src_h_reg, dst_h_reg;
    logic [8:0]  dst_w_reg;
    logic        alpha_cfg_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= 13'd1;
            src_h_reg <= 13'd1;
            dst_w_reg <= 9'd1;
            dst_h_reg <= 13'd1;
            alpha_cfg_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                bfds_pkg::CFG_SRC_W: src_w_reg <= cfg_data;
                bfds_pkg::CFG_SRC_H: src_h_reg <= cfg_data;
                bfds_pkg::CFG_DST_W: dst_w_reg <= cfg_data[8:0];
                bfds_pkg::CFG_DST_H: dst_h_reg <= cfg_data;
                bfds_pkg::CFG_ALPHA: alpha_cfg_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped image sizes
    logic [PW-1:0] cl_sw, cl_sh, cl_dw, cl_dh;
    always_comb begin
        cl_sw = (src_w_reg == '0) ? PW'(1) :
                ({19'd0, src_w_reg} > MAX_SRC_SIZE) ? PW'(MAX_SRC_SIZE) : PW'(src_w_reg);
        cl_sh = (src_h_reg == '0) ? PW'(1) :
                ({19'd0, src_h_reg} > MAX_SRC_SIZE) ? PW'(MAX_SRC_SIZE) : PW'(src_h_reg);
        cl_dw = (dst_w_reg == '0) ? PW'(1) : PW'(dst_w_reg);
        if ({23'd0, cl_dw} > MAX_DST_WIDTH) cl_dw = PW'(MAX_DST_WIDTH);
        if (cl_dw > cl_sw) cl_dw = cl_sw;
        cl_dh = (dst_h_reg == '0) ? PW'(1) : PW'(dst_h_reg);
        if (cl_dh > cl_sh) cl_dh = cl_sh;
    end

    // per-image latched values and position counters
    logic [PW-1:0] sw_reg, sh_reg, dw_reg, dh_reg, hs_reg, vs_reg;
    logic [AR-1:0] area_reg;
    logic          alpha_reg;
    logic [PW-1:0] scol_reg, srow_reg, cib_reg, rib_reg, dcol_reg, drow_reg;
    state_t        state_reg;

    // scale factors by a small serial divider (repeated subtraction of shifted divisor)
    logic [PW-1:0] hrem_reg, vrem_reg, hq_reg, vq_reg;
    logic [2*PW-1:0] hdv_reg, vdv_reg;
    logic [CNT_W-1:0] scnt_reg;

    // pixel hold and sum memory, one word holds the four channel sums of a column
    logic [3:0][7:0] px_reg;
    logic [3:0][SW-1:0] mem [MAX_DST_WIDTH];
    logic [3:0][SW-1:0] rd_reg;
    logic [AW-1:0] addr;
    logic active, first, closes;
    logic [3:0][SW-1:0] wsum;

    assign addr = dcol_reg[AW-1:0];
    assign active = (dcol_reg < dw_reg) && (drow_reg < dh_reg);
    assign first = (cib_reg == '0) && (rib_reg == '0);
    assign closes = active && (rib_reg + 1'b1 == vs_reg) && (cib_reg + 1'b1 == hs_reg);
    always_comb begin
        for (int c = 0; c < 4; c++)
            wsum[c] = first ? SW'(px_reg[c]) : rd_reg[c] + SW'(px_reg[c]);
    end

    // output register state
    logic out_full;
    logic [3:0][7:0] out_reg;
    logic out_last_reg;

    // divider, started only when its result has a free place to land
    logic div_busy, div_done, div_last, div_start;
    logic [3:0][7:0] div_q;
    bfds_pkg::div_req_t req;
    assign req.sums = wsum;
    assign req.alpha = alpha_reg;
    assign req.last = (dcol_reg + 1'b1 == dw_reg) && (drow_reg + 1'b1 == dh_reg);
    assign div_start = (state_reg == ST_RMW) && closes && !div_busy && !div_done && !out_full;

    bfds_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .req(req),
        .divisor(area_reg), .busy(div_busy), .done(div_done), .quot(div_q),
        .last(div_last)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RMW && active && (!closes || div_start)) begin
            mem[addr] <= wsum;
        end
        rd_reg <= mem[addr];
    end

    // main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scol_reg <= '0; srow_reg <= '0; cib_reg <= '0; rib_reg <= '0;
            dcol_reg <= '0; drow_reg <= '0;
            sw_reg <= PW'(1); sh_reg <= PW'(1); dw_reg <= PW'(1); dh_reg <= PW'(1);
            hs_reg <= PW'(1); vs_reg <= PW'(1); area_reg <= AR'(1);
            alpha_reg <= 1'b1;
            scnt_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        px_reg <= {s_alpha_in, s_blue_in, s_green_in, s_red_in};
                        if (scol_reg == '0 && srow_reg == '0) begin
                            sw_reg <= cl_sw; sh_reg <= cl_sh;
                            dw_reg <= cl_dw; dh_reg <= cl_dh;
                            alpha_reg <= alpha_cfg_reg;
                            hrem_reg <= cl_sw; vrem_reg <= cl_sh;
                            hq_reg <= '0; vq_reg <= '0;
                            hdv_reg <= {cl_dw, {PW{1'b0}}} >> 1;
                            vdv_reg <= {cl_dh, {PW{1'b0}}} >> 1;
                            scnt_reg <= CNT_W'(PW);
                            state_reg <= ST_LATCH;
                        end else begin
                            state_reg <= ST_RMW;
                        end
                    end
                end
                ST_LATCH: begin
                    if (scnt_reg != '0) begin
                        hq_reg <= {hq_reg[PW-2:0], ({{PW{1'b0}}, hrem_reg} >= hdv_reg)};
                        if ({{PW{1'b0}}, hrem_reg} >= hdv_reg)
                            hrem_reg <= hrem_reg - hdv_reg[PW-1:0];
                        vq_reg <= {vq_reg[PW-2:0], ({{PW{1'b0}}, vrem_reg} >= vdv_reg)};
                        if ({{PW{1'b0}}, vrem_reg} >= vdv_reg)
                            vrem_reg <= vrem_reg - vdv_reg[PW-1:0];
                        hdv_reg <= hdv_reg >> 1;
                        vdv_reg <= vdv_reg >> 1;
                        scnt_reg <= scnt_reg - 1'b1;
                    end else begin
                        hs_reg <= hq_reg;
                        vs_reg <= vq_reg;
                        area_reg <= AR'(hq_reg) * AR'(vq_reg);
                        state_reg <= ST_RMW;
                    end
                end
                ST_RMW: begin
                    if (!closes || div_start) begin
                        state_reg <= ST_IDLE;
                        if (scol_reg + 1'b1 >= sw_reg) begin
                            scol_reg <= '0; cib_reg <= '0; dcol_reg <= '0;
                            if (srow_reg + 1'b1 >= sh_reg) begin
                                srow_reg <= '0; rib_reg <= '0; drow_reg <= '0;
                            end else begin
                                srow_reg <= srow_reg + 1'b1;
                                if (rib_reg + 1'b1 >= vs_reg) begin
                                    rib_reg <= '0;
                                    if (drow_reg < dh_reg) drow_reg <= drow_reg + 1'b1;
                                end else begin
                                    rib_reg <= rib_reg + 1'b1;
                                end
                            end
                        end else begin
                            scol_reg <= scol_reg + 1'b1;
                            if (cib_reg + 1'b1 >= hs_reg) begin
                                cib_reg <= '0;
                                if (dcol_reg < dw_reg) dcol_reg <= dcol_reg + 1'b1;
                            end else begin
                                cib_reg <= cib_reg + 1'b1;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full <= 1'b0;
        end else if (div_done) begin
            out_full <= 1'b1;
            out_reg <= div_q;
            out_last_reg <= div_last;
        end else if (m_ready) begin
            out_full <= 1'b0;
        end
    end

    assign m_valid = out_full;
    assign m_red_out = out_reg[0];
    assign m_green_out = out_reg[1];
    assign m_blue_out = out_reg[2];
    assign m_alpha_out = out_reg[3];
    assign m_last_pixel = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> !out_full) else $error("result overwrote pending item");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_scale_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RMW |-> hs_reg != '0 && vs_reg != '0) else $error("zero scale");
`endif
endmodule
